### rtl/matrix_determinant_cofactor_macros.svh
// ----------------------------------------------------------------------------
// matrix_determinant_cofactor assertion macros
// Shared concurrent assertion forms for the determinant block.
// ----------------------------------------------------------------------------
`ifndef MATRIX_DETERMINANT_COFACTOR_MACROS_SVH
`define MATRIX_DETERMINANT_COFACTOR_MACROS_SVH

// same-cycle implication
`define MDC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mdc_pkg.sv
// ----------------------------------------------------------------------------
// mdc_pkg
// Shared types and constants of the cofactor determinant block.
// ----------------------------------------------------------------------------
package mdc_pkg;

    localparam int MATRIX_SIZE_W     = 3;
    localparam int DET_W             = 64;
    localparam int LIMB_W            = 32;
    localparam logic [MATRIX_SIZE_W-1:0] MATRIX_SIZE_RESET = 3'd4;

    typedef struct packed {
        logic mat_we;
        logic rd_en;
        logic mul_en;
        logic neg;
        logic acc_clr;
        logic d_we;
        logic d_one;
        logic out_load;
    } t_dp_cmd;

endpackage

### rtl/mdc_datapath.sv
// ----------------------------------------------------------------------------
// mdc_datapath
// Matrix store, minor store, limb-serial multiplier, accumulator and result
// register with 64-bit saturation.
// ----------------------------------------------------------------------------
module mdc_datapath #(
    parameter int MAX_SIZE   = 4,
    parameter int ELEM_WIDTH = 12
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  mdc_pkg::t_dp_cmd                          i_cmd,
    input  logic [((MAX_SIZE*MAX_SIZE > 1) ? $clog2(MAX_SIZE*MAX_SIZE) : 1)-1:0] i_mat_waddr,
    input  logic [((MAX_SIZE*MAX_SIZE > 1) ? $clog2(MAX_SIZE*MAX_SIZE) : 1)-1:0] i_mat_raddr,
    input  logic [MAX_SIZE-1:0]                       i_d_raddr,
    input  logic [MAX_SIZE-1:0]                       i_d_waddr,
    input  logic [(((MAX_SIZE*(ELEM_WIDTH+2)+1+31)/32 > 1) ?
                   $clog2((MAX_SIZE*(ELEM_WIDTH+2)+1+31)/32) : 1)-1:0] i_limb,
    input  logic signed [ELEM_WIDTH-1:0]              i_element_value,
    output logic signed [mdc_pkg::DET_W-1:0]          o_det_value,
    output logic                                      o_overflow
);

    localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIMB_W = mdc_pkg::LIMB_W;
    localparam int ACC_W  = MAX_SIZE * (ELEM_WIDTH + 2) + 1;
    localparam int NLIMB  = (ACC_W + LIMB_W - 1) / LIMB_W;
    localparam int LW     = (NLIMB > 1) ? $clog2(NLIMB) : 1;
    localparam int PADW   = NLIMB * LIMB_W;
    localparam int PPW    = LIMB_W + ELEM_WIDTH + 2;
    localparam int XW     = (ACC_W > PPW) ? ACC_W : PPW;
    localparam int SHW    = LW + $clog2(LIMB_W);
    localparam int DW     = mdc_pkg::DET_W;
    localparam int EXT_W  = (ACC_W > DW) ? ACC_W : DW;

    logic signed [ELEM_WIDTH-1:0] r_mat [DEPTH];
    logic [ACC_W-1:0]             r_dmem [1 << MAX_SIZE];
    logic signed [ELEM_WIDTH-1:0] r_elem;
    logic [ACC_W-1:0]             r_dval;
    logic signed [PPW-1:0]        r_pp;
    logic [LW-1:0]                r_pp_limb;
    logic                         r_pp_vld;
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [DW-1:0]         r_det;
    logic                         r_ovf;

    logic [PADW-1:0]              w_dpad;
    logic [LIMB_W-1:0]            w_limb [NLIMB];
    logic signed [LIMB_W:0]       w_mul_a;
    logic signed [ELEM_WIDTH:0]   w_elem_ext;
    logic signed [ELEM_WIDTH:0]   w_mul_b;
    logic signed [XW-1:0]         w_pp_ext;
    logic [SHW-1:0]               w_shamt;
    logic [XW-1:0]                w_term;
    logic signed [EXT_W-1:0]      w_acc_ext;
    logic [EXT_W-DW:0]            w_hi;
    logic                         w_ovf;
    logic signed [DW-1:0]         w_sat;

    // matrix store
    always_ff @(posedge i_clk) begin
        if (i_cmd.mat_we) begin
            r_mat[i_mat_waddr] <= i_element_value;
        end
        if (i_cmd.rd_en) begin
            r_elem <= r_mat[i_mat_raddr];
        end
    end

    // minor store, indexed by column set
    always_ff @(posedge i_clk) begin
        if (i_cmd.d_we) begin
            r_dmem[i_d_waddr] <= i_cmd.d_one ? ACC_W'(1) : r_acc;
        end
        if (i_cmd.rd_en) begin
            r_dval <= r_dmem[i_d_raddr];
        end
    end

    assign w_dpad = PADW'(r_dval);

    always_comb begin
        for (int i = 0; i < NLIMB; i++) begin
            w_limb[i] = w_dpad[i*LIMB_W +: LIMB_W];
        end
    end

    assign w_mul_a    = signed'({1'b0, w_limb[i_limb]});
    assign w_elem_ext = {r_elem[ELEM_WIDTH-1], r_elem};
    assign w_mul_b    = i_cmd.neg ? -w_elem_ext : w_elem_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_vld <= 1'b0;
        end else begin
            r_pp_vld <= i_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_pp      <= PPW'(w_mul_a) * PPW'(w_mul_b);
            r_pp_limb <= i_limb;
        end
    end

    assign w_pp_ext = XW'(r_pp);
    assign w_shamt  = SHW'(r_pp_limb) * SHW'(LIMB_W);
    assign w_term   = w_pp_ext << w_shamt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_pp_vld) begin
            r_acc <= r_acc + signed'(w_term[ACC_W-1:0]);
        end
    end

    assign w_acc_ext = EXT_W'(r_acc);
    assign w_hi      = w_acc_ext[EXT_W-1:DW-1];
    assign w_ovf     = !((&w_hi) || (~|w_hi));

    always_comb begin
        if (!w_ovf) begin
            w_sat = w_acc_ext[DW-1:0];
        end else if (w_acc_ext[EXT_W-1]) begin
            w_sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(DW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_det <= w_sat;
            r_ovf <= w_ovf;
        end
    end

    assign o_det_value = r_det;
    assign o_overflow  = r_ovf;

endmodule

### rtl/mdc_ctrl.sv
// ----------------------------------------------------------------------------
// mdc_ctrl
// Load counter and expansion sequencer: walks the column sets in increasing
// order and issues one limb multiply per cycle for every cofactor term.
// ----------------------------------------------------------------------------
module mdc_ctrl #(
    parameter int MAX_SIZE   = 4,
    parameter int ELEM_WIDTH = 12
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_wr_en,
    input  logic [mdc_pkg::MATRIX_SIZE_W-1:0]         i_cfg_wr_data,
    input  logic                                      i_valid,
    output logic                                      o_stall,
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output mdc_pkg::t_dp_cmd                          o_cmd,
    output logic [((MAX_SIZE*MAX_SIZE > 1) ? $clog2(MAX_SIZE*MAX_SIZE) : 1)-1:0] o_mat_waddr,
    output logic [((MAX_SIZE*MAX_SIZE > 1) ? $clog2(MAX_SIZE*MAX_SIZE) : 1)-1:0] o_mat_raddr,
    output logic [MAX_SIZE-1:0]                       o_d_raddr,
    output logic [MAX_SIZE-1:0]                       o_d_waddr,
    output logic [(((MAX_SIZE*(ELEM_WIDTH+2)+1+31)/32 > 1) ?
                   $clog2((MAX_SIZE*(ELEM_WIDTH+2)+1+31)/32) : 1)-1:0] o_limb
);

    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int NW    = $clog2(MAX_SIZE + 1);
    localparam int COLW  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int SW    = mdc_pkg::MATRIX_SIZE_W;
    localparam int ACC_W = MAX_SIZE * (ELEM_WIDTH + 2) + 1;
    localparam int NLIMB = (ACC_W + mdc_pkg::LIMB_W - 1) / mdc_pkg::LIMB_W;
    localparam int LW    = (NLIMB > 1) ? $clog2(NLIMB) : 1;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_INIT  = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_ADD   = 3'd4;
    localparam logic [2:0] ST_WRITE = 3'd5;

    logic [2:0]          r_state,     n_state;
    logic [SW-1:0]       r_size,      n_size;
    logic [CW-1:0]       r_cnt,       n_cnt;
    logic [MAX_SIZE-1:0] r_mask,      n_mask;
    logic [MAX_SIZE-1:0] r_rem,       n_rem;
    logic                r_neg,       n_neg;
    logic [LW-1:0]       r_limb,      n_limb;
    logic                r_out_valid, n_out_valid;

    logic [NW-1:0]       w_n;
    logic [CW-1:0]       w_total;
    logic [MAX_SIZE-1:0] w_full;
    logic [NW-1:0]       w_pop;
    logic [NW-1:0]       w_row;
    logic [COLW-1:0]     w_col;
    logic [MAX_SIZE-1:0] w_bit;
    logic [CW-1:0]       w_raddr;
    logic                w_accept;
    mdc_pkg::t_dp_cmd    w_cmd;

    always_comb begin
        if (r_size == '0) begin
            w_n = NW'(1);
        end else if (r_size > SW'(MAX_SIZE)) begin
            w_n = NW'(MAX_SIZE);
        end else begin
            w_n = NW'(r_size);
        end
    end

    assign w_total = CW'(w_n) * CW'(w_n);
    assign w_full  = ~({MAX_SIZE{1'b1}} << w_n);

    always_comb begin
        w_pop = '0;
        for (int i = 0; i < MAX_SIZE; i++) begin
            w_pop = w_pop + NW'(r_mask[i]);
        end
    end

    always_comb begin
        w_col = '0;
        for (int i = MAX_SIZE - 1; i >= 0; i--) begin
            if (r_rem[i]) begin
                w_col = COLW'(i);
            end
        end
    end

    assign w_row    = w_n - w_pop;
    assign w_bit    = MAX_SIZE'(1) << w_col;
    assign w_raddr  = CW'(w_row) * CW'(w_n) + CW'(w_col);
    assign w_accept = i_valid && (r_state == ST_LOAD);

    always_comb begin
        n_state     = r_state;
        n_size      = r_size;
        n_cnt       = r_cnt;
        n_mask      = r_mask;
        n_rem       = r_rem;
        n_neg       = r_neg;
        n_limb      = r_limb;
        w_cmd       = '0;
        w_cmd.neg   = r_neg;

        unique case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    w_cmd.mat_we = 1'b1;
                    if (r_cnt == w_total - CW'(1)) begin
                        n_cnt   = '0;
                        n_mask  = '0;
                        n_state = ST_INIT;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
            end
            ST_INIT: begin
                w_cmd.d_we  = 1'b1;
                w_cmd.d_one = 1'b1;
                n_mask      = MAX_SIZE'(1);
                n_rem       = MAX_SIZE'(1);
                n_state     = ST_START;
            end
            ST_START: begin
                w_cmd.acc_clr = 1'b1;
                w_cmd.rd_en   = 1'b1;
                n_rem         = r_rem & ~w_bit;
                n_neg         = 1'b0;
                n_limb        = '0;
                n_state       = ST_MUL;
            end
            ST_MUL: begin
                w_cmd.mul_en = 1'b1;
                if (r_limb == LW'(NLIMB - 1)) begin
                    if (r_rem != '0) begin
                        w_cmd.rd_en = 1'b1;
                        n_rem       = r_rem & ~w_bit;
                        n_neg       = ~r_neg;
                        n_limb      = '0;
                    end else begin
                        n_state = ST_ADD;
                    end
                end else begin
                    n_limb = r_limb + LW'(1);
                end
            end
            ST_ADD: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                w_cmd.d_we = 1'b1;
                if (r_mask == w_full) begin
                    if (!r_out_valid || !i_stall) begin
                        w_cmd.out_load = 1'b1;
                        n_state        = ST_LOAD;
                    end
                end else begin
                    n_mask  = r_mask + MAX_SIZE'(1);
                    n_rem   = r_mask + MAX_SIZE'(1);
                    n_state = ST_START;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase

        if (i_cfg_wr_en) begin
            n_size = i_cfg_wr_data;
            n_cnt  = '0;
        end

        n_out_valid = r_out_valid && i_stall;
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_size      <= mdc_pkg::MATRIX_SIZE_RESET;
            r_cnt       <= '0;
            r_mask      <= '0;
            r_rem       <= '0;
            r_neg       <= 1'b0;
            r_limb      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_cnt       <= n_cnt;
            r_mask      <= n_mask;
            r_rem       <= n_rem;
            r_neg       <= n_neg;
            r_limb      <= n_limb;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall     = (r_state != ST_LOAD);
    assign o_valid     = r_out_valid;
    assign o_cmd       = w_cmd;
    assign o_mat_waddr = r_cnt[AW-1:0];
    assign o_mat_raddr = w_raddr[AW-1:0];
    assign o_d_raddr   = r_mask & ~w_bit;
    assign o_d_waddr   = r_mask;
    assign o_limb      = r_limb;

endmodule

### rtl/matrix_determinant_cofactor.sv
// ----------------------------------------------------------------------------
// matrix_determinant_cofactor
// Loads an n-by-n matrix one element per item, then emits its determinant.
// Load: one item per cycle; the item completing the matrix starts the expansion.
// Expansion: walks the column sets, multiplying by the 32-bit limbs of the
// accumulator (2 by default) on the single shared limb multiplier.
// Input is stalled during the expansion.
// Synchronous active-low reset: size 4, load count cleared, no result pending.
// ----------------------------------------------------------------------------
`include "matrix_determinant_cofactor_macros.svh"

module matrix_determinant_cofactor #(
    parameter int MAX_SIZE   = 4,
    parameter int ELEM_WIDTH = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [mdc_pkg::MATRIX_SIZE_W-1:0]    i_cfg_wr_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [ELEM_WIDTH-1:0]         i_element_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [mdc_pkg::DET_W-1:0]     o_det_value,
    output logic                                 o_overflow
);

    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ACC_W = MAX_SIZE * (ELEM_WIDTH + 2) + 1;
    localparam int NLIMB = (ACC_W + mdc_pkg::LIMB_W - 1) / mdc_pkg::LIMB_W;
    localparam int LW    = (NLIMB > 1) ? $clog2(NLIMB) : 1;

    mdc_pkg::t_dp_cmd    w_cmd;
    logic [AW-1:0]       w_mat_waddr;
    logic [AW-1:0]       w_mat_raddr;
    logic [MAX_SIZE-1:0] w_d_raddr;
    logic [MAX_SIZE-1:0] w_d_waddr;
    logic [LW-1:0]       w_limb;

    mdc_ctrl #(
        .MAX_SIZE   (MAX_SIZE),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_cmd         (w_cmd),
        .o_mat_waddr   (w_mat_waddr),
        .o_mat_raddr   (w_mat_raddr),
        .o_d_raddr     (w_d_raddr),
        .o_d_waddr     (w_d_waddr),
        .o_limb        (w_limb)
    );

    mdc_datapath #(
        .MAX_SIZE   (MAX_SIZE),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_mat_waddr     (w_mat_waddr),
        .i_mat_raddr     (w_mat_raddr),
        .i_d_raddr       (w_d_raddr),
        .i_d_waddr       (w_d_waddr),
        .i_limb          (w_limb),
        .i_element_value (i_element_value),
        .o_det_value     (o_det_value),
        .o_overflow      (o_overflow)
    );

    `MDC_ASSERT_SAME(a_no_load_while_busy, i_clk, i_rst_n, w_cmd.mul_en, o_stall, "multiply while input open")
    `MDC_ASSERT_SAME(a_no_result_overwrite, i_clk, i_rst_n, w_cmd.out_load, !(o_valid && i_stall), "pending result overwritten")
    `MDC_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, w_cmd.out_load, o_valid, "loaded result not valid")
    `MDC_ASSERT_SAME(a_no_minor_rw_clash, i_clk, i_rst_n, w_cmd.d_we, !w_cmd.rd_en, "minor store read during write")

endmodule
